>>> rtl/core/assert_macros.svh
// assertion helpers shared by the rtl core files
// each check is compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check that is switched off while reset is high
`define CHK_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also runs through reset
`define CHK_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_ASSERT(name, clk, rst, prop, msg)
`define CHK_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> rtl/core/mcp_pkg.sv
// ----------------------------------------------------------------------------
// mcp_pkg
// types and constants of the midi chunk header parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcp_pkg;

  // one file byte with its framing flags
  typedef struct packed {
    logic       start_of_file;
    logic [7:0] data_byte;
    logic       stream_ended;
  } in_word_t;

  // one parser report
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] format_type;
    logic [15:0] track_total;
    logic [15:0] ticks_per_beat;
    logic [15:0] track_number;
    logic [31:0] body_offset;
    logic [31:0] body_length;
    logic        finished;
    logic        error_code;
  } out_word_t;

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_TRACK    = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic ERR_INVALID_FORMAT = 1'b0;
  localparam logic ERR_END_OF_STREAM  = 1'b1;

  localparam logic [31:0] HEADER_SIZE = 32'd6;

  // byte idx of "MThd" (is_trk = 0) or "MTrk" (is_trk = 1)
  function automatic logic [7:0] magic_byte(input logic is_trk, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h4D;
      2'd1:    b = 8'h54;
      2'd2:    b = is_trk ? 8'h72 : 8'h68;
      default: b = is_trk ? 8'h6B : 8'h64;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/midi_chunk_header_parser_top.sv
// ----------------------------------------------------------------------------
// midi_chunk_header_parser_top
// byte-serial parser of standard midi file chunk headers
// ----------------------------------------------------------------------------
// usage:
//   src channel: one word per file byte (valid/ready). start_of_file restarts
//   the parser with this word's byte as file byte 0; stream_ended marks the
//   end of the stream and its data byte is ignored.
//   res channel: at most one word per src word - header info, a track record
//   (index, body offset, body length), parse complete, or an error code.
//   throughput: one src word per cycle while src ready is high; the parser
//   state updates on each accepted word and its result is registered.
//   res words leave through a two-entry output stage (output register plus a
//   skid register), so src words keep flowing while one result waits; src
//   ready drops only while the skid register is occupied.
//   reset (rst, synchronous): parser idle until a start_of_file word, both
//   output entries empty. words seen before any start, after completion or
//   after an error are dropped without a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module midi_chunk_header_parser_top #(
  parameter int POSITION_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  mcp_pkg::in_word_t src_word,
  output logic              res_valid,
  input  logic              res_ready,
  output mcp_pkg::out_word_t res_word
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HMAGIC,
    PH_HSIZE,
    PH_HWORDS,
    PH_CMAGIC,
    PH_CSIZE,
    PH_SKIP,
    PH_DONE,
    PH_FAIL
  } phase_t;

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  // parser state
  phase_t                   phase;
  logic [2:0]               byte_count;
  logic [31:0]              gather_word;
  logic                     magic_is_track;
  logic [15:0]              declared_tracks;
  logic [15:0]              found_tracks;
  logic [POSITION_BITS-1:0] file_position;
  logic [31:0]              skip_remaining;

  phase_t                   phase_next;
  logic [2:0]               byte_count_next;
  logic [31:0]              gather_word_next;
  logic                     magic_is_track_next;
  logic [15:0]              declared_tracks_next;
  logic [15:0]              found_tracks_next;
  logic [POSITION_BITS-1:0] file_position_next;
  logic [31:0]              skip_remaining_next;

  // output stage
  logic               skid_valid;
  mcp_pkg::out_word_t skid_word;

  logic               src_fire;
  logic               res_hit;
  mcp_pkg::out_word_t res_next;

  // skid register free means a result of this cycle always has a place
  assign src_ready = !skid_valid;
  assign src_fire  = src_valid && src_ready;

  // parser step for the current src word
  always_comb begin
    logic [31:0] shifted;
    logic        hit;
    logic        mt_new;
    logic [15:0] ft_inc;
    logic [31:0] skip_dec;

    // a start wipes the state before this byte is looked at
    if (src_word.start_of_file) begin
      phase_next           = PH_HMAGIC;
      byte_count_next      = 3'd0;
      gather_word_next     = 32'd0;
      magic_is_track_next  = 1'b0;
      declared_tracks_next = 16'd0;
      found_tracks_next    = 16'd0;
      file_position_next   = '0;
      skip_remaining_next  = 32'd0;
    end else begin
      phase_next           = phase;
      byte_count_next      = byte_count;
      gather_word_next     = gather_word;
      magic_is_track_next  = magic_is_track;
      declared_tracks_next = declared_tracks;
      found_tracks_next    = found_tracks;
      file_position_next   = file_position;
      skip_remaining_next  = skip_remaining;
    end

    res_hit  = 1'b0;
    res_next = '0;

    shifted  = {gather_word_next[23:0], src_word.data_byte};
    hit      = (src_word.data_byte ==
                mcp_pkg::magic_byte(phase_next == PH_CMAGIC, byte_count_next[1:0]));
    mt_new   = ((byte_count_next == 3'd0) ? 1'b1 : magic_is_track_next) & hit;
    ft_inc   = 16'(found_tracks_next + 16'd1);
    skip_dec = 32'(skip_remaining_next - 32'd1);

    if (phase_next == PH_IDLE || phase_next == PH_DONE || phase_next == PH_FAIL) begin
      // dropped
    end else if (src_word.stream_ended) begin
      res_hit              = 1'b1;
      res_next.result_kind = mcp_pkg::KIND_ERROR;
      res_next.error_code  = (phase_next == PH_HMAGIC || phase_next == PH_HSIZE ||
                              phase_next == PH_CMAGIC) ? mcp_pkg::ERR_INVALID_FORMAT
                                                       : mcp_pkg::ERR_END_OF_STREAM;
      phase_next           = PH_FAIL;
    end else begin
      file_position_next = file_position_next + POS_ONE;
      case (phase_next)
        PH_HMAGIC, PH_CMAGIC: begin
          magic_is_track_next = mt_new;
          if (byte_count_next < 3'd3) begin
            byte_count_next = byte_count_next + 3'd1;
          end else begin
            byte_count_next  = 3'd0;
            gather_word_next = 32'd0;
            if (phase_next == PH_HMAGIC) begin
              if (!mt_new) begin
                res_hit              = 1'b1;
                res_next.result_kind = mcp_pkg::KIND_ERROR;
                res_next.error_code  = mcp_pkg::ERR_INVALID_FORMAT;
                phase_next           = PH_FAIL;
              end else begin
                magic_is_track_next = 1'b0;
                phase_next          = PH_HSIZE;
              end
            end else begin
              phase_next = PH_CSIZE;
            end
          end
        end
        PH_HSIZE: begin
          gather_word_next = shifted;
          if (byte_count_next < 3'd3) begin
            byte_count_next = byte_count_next + 3'd1;
          end else begin
            byte_count_next = 3'd0;
            if (shifted != mcp_pkg::HEADER_SIZE) begin
              res_hit              = 1'b1;
              res_next.result_kind = mcp_pkg::KIND_ERROR;
              res_next.error_code  = mcp_pkg::ERR_INVALID_FORMAT;
              phase_next           = PH_FAIL;
            end else begin
              gather_word_next = 32'd0;
              phase_next       = PH_HWORDS;
            end
          end
        end
        PH_HWORDS: begin
          // format and track count fill the word, the timebase overwrites its low half
          if (byte_count_next < 3'd4) begin
            gather_word_next = shifted;
            if (byte_count_next == 3'd3) begin
              declared_tracks_next = shifted[15:0];
            end
          end else begin
            gather_word_next = {gather_word_next[31:16], gather_word_next[7:0],
                                src_word.data_byte};
          end
          if (byte_count_next < 3'd5) begin
            byte_count_next = byte_count_next + 3'd1;
          end else begin
            byte_count_next         = 3'd0;
            phase_next              = (declared_tracks_next == 16'd0) ? PH_DONE : PH_CMAGIC;
            res_hit                 = 1'b1;
            res_next.result_kind    = mcp_pkg::KIND_HEADER;
            res_next.format_type    = gather_word_next[31:16];
            res_next.track_total    = declared_tracks_next;
            res_next.ticks_per_beat = gather_word_next[15:0];
            res_next.finished       = (declared_tracks_next == 16'd0);
          end
        end
        PH_CSIZE: begin
          if (byte_count_next < 3'd3) begin
            gather_word_next = shifted;
            byte_count_next  = byte_count_next + 3'd1;
          end else begin
            byte_count_next  = 3'd0;
            gather_word_next = 32'd0;
            if (magic_is_track_next) begin
              res_hit               = 1'b1;
              res_next.result_kind  = mcp_pkg::KIND_TRACK;
              res_next.track_number = found_tracks_next;
              res_next.body_offset  = 32'(file_position_next);
              res_next.body_length  = shifted;
              res_next.finished     = (shifted == 32'd0) && (ft_inc == declared_tracks_next);
              found_tracks_next     = ft_inc;
            end
            magic_is_track_next = 1'b0;
            if (shifted == 32'd0) begin
              phase_next = (found_tracks_next == declared_tracks_next) ? PH_DONE : PH_CMAGIC;
            end else begin
              skip_remaining_next = shifted;
              phase_next          = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 32'd0) begin
            if (found_tracks_next == declared_tracks_next) begin
              phase_next           = PH_DONE;
              res_hit              = 1'b1;
              res_next.result_kind = mcp_pkg::KIND_COMPLETE;
              res_next.finished    = 1'b1;
            end else begin
              phase_next = PH_CMAGIC;
            end
          end
        end
        default: begin
          // idle, done and fail never reach here
        end
      endcase
    end
  end

  // parser state and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_count      <= 3'd0;
      gather_word     <= 32'd0;
      magic_is_track  <= 1'b0;
      declared_tracks <= 16'd0;
      found_tracks    <= 16'd0;
      file_position   <= '0;
      skip_remaining  <= 32'd0;
      res_valid       <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (src_fire) begin
        phase           <= phase_next;
        byte_count      <= byte_count_next;
        gather_word     <= gather_word_next;
        magic_is_track  <= magic_is_track_next;
        declared_tracks <= declared_tracks_next;
        found_tracks    <= found_tracks_next;
        file_position   <= file_position_next;
        skip_remaining  <= skip_remaining_next;
      end
      if (res_valid && res_ready) begin
        // output taken: refill from skid first, else from the new result
        if (skid_valid) begin
          res_word   <= skid_word;
          skid_valid <= 1'b0;
        end else if (src_fire && res_hit) begin
          res_word <= res_next;
        end else begin
          res_valid <= 1'b0;
        end
      end else if (res_valid) begin
        // receiver stalled: park the new result
        if (src_fire && res_hit) begin
          skid_word  <= res_next;
          skid_valid <= 1'b1;
        end
      end else if (src_fire && res_hit) begin
        res_word  <= res_next;
        res_valid <= 1'b1;
      end
    end
  end

  `CHK_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> res_valid, "skid holds a word while output is empty")
  `CHK_ASSERT_ALWAYS(a_reset_empties, clk, $past(rst) |-> (!res_valid && !skid_valid), "output not empty after reset")
  `CHK_ASSERT(a_skip_nonzero, clk, rst, (phase == PH_SKIP) |-> (skip_remaining != 32'd0), "skip phase with nothing to skip")
  `CHK_ASSERT(a_done_all_tracks, clk, rst, (phase == PH_DONE) |-> (found_tracks == declared_tracks), "parse done with tracks missing")
  `CHK_ASSERT(a_count_range, clk, rst, (phase != PH_HWORDS && phase != PH_FAIL) |-> (byte_count <= 3'd3), "byte count too big")

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench of the midi chunk header parser
// ----------------------------------------------------------------------------
// file bytes go in one word per handshake; a behavioral parser in the bench
// predicts every report and a monitor compares each accepted res word with the
// oldest prediction. directed files cover the corner cases, random files
// (clean, cut short by a stream end, or with one corrupted byte) run under
// three idle mixes, and one file of many empty tracks is sent while the
// receiver holds off so the output stage fills and src ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int          TAIL_CYCLES = 6;
  localparam logic [31:0] HDR_MAGIC   = 32'h4D546864;  // "MThd"
  localparam logic [31:0] TRK_MAGIC   = 32'h4D54726B;  // "MTrk"

  typedef enum logic [3:0] {
    PP_IDLE, PP_HMAGIC, PP_HSIZE, PP_HWORDS, PP_CMAGIC, PP_CSIZE, PP_SKIP, PP_DONE, PP_FAIL
  } parse_phase_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               src_valid = 1'b0;
  logic               src_ready;
  mcp_pkg::in_word_t  src_word  = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  mcp_pkg::out_word_t res_word;

  midi_chunk_header_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_word  (src_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  always #10 clk = ~clk;

  // bench copy of the parser state
  parse_phase_t pp_phase;
  logic [2:0]   pp_count;
  logic [31:0]  pp_gather;
  logic         pp_match;
  logic [15:0]  pp_declared;
  logic [15:0]  pp_found;
  logic [31:0]  pp_position;
  logic [31:0]  pp_skip;

  mcp_pkg::out_word_t expected_reports[$];
  int           mismatch_count = 0;

  int           src_idle_pct = 0;
  int           res_idle_pct = 0;

  // receiver hold-off request, taken over by the receiver process
  int           hold_off_len  = 0;
  int           hold_off_id   = 0;
  int           hold_off_seen = 0;
  int           hold_left     = 0;

  logic [7:0]   file_bytes[$];

  task automatic reset_parser();
    pp_phase    = PP_IDLE;
    pp_count    = '0;
    pp_gather   = '0;
    pp_match    = 1'b0;
    pp_declared = '0;
    pp_found    = '0;
    pp_position = '0;
    pp_skip     = '0;
  endtask

  task automatic raise_error(input logic code);
    mcp_pkg::out_word_t r;
    r            = '0;
    r.result_kind = mcp_pkg::KIND_ERROR;
    r.error_code  = code;
    pp_phase      = PP_FAIL;
    expected_reports.push_back(r);
  endtask

  // advances the bench parser by one accepted word
  task automatic predict_report(input mcp_pkg::in_word_t w);
    mcp_pkg::out_word_t r;
    logic [31:0] want;
    logic [31:0] sel;
    logic        hit;
    logic [31:0] len;
    r = '0;
    if (w.start_of_file) begin
      reset_parser();
      pp_phase = PP_HMAGIC;
    end
    if (pp_phase == PP_IDLE || pp_phase == PP_DONE || pp_phase == PP_FAIL) return;
    if (w.stream_ended) begin
      if (pp_phase == PP_HMAGIC || pp_phase == PP_HSIZE || pp_phase == PP_CMAGIC)
        raise_error(mcp_pkg::ERR_INVALID_FORMAT);
      else
        raise_error(mcp_pkg::ERR_END_OF_STREAM);
      return;
    end
    pp_position = pp_position + 32'd1;
    case (pp_phase)
      PP_HMAGIC, PP_CMAGIC: begin
        want     = (pp_phase == PP_HMAGIC) ? HDR_MAGIC : TRK_MAGIC;
        sel      = want >> (8 * (3 - pp_count[1:0]));
        hit      = (w.data_byte == sel[7:0]);
        pp_match = ((pp_count == 3'd0) ? 1'b1 : pp_match) & hit;
        if (pp_count < 3'd3) begin
          pp_count = pp_count + 3'd1;
        end else begin
          pp_count  = '0;
          pp_gather = '0;
          if (pp_phase == PP_HMAGIC) begin
            if (!pp_match) begin
              raise_error(mcp_pkg::ERR_INVALID_FORMAT);
            end else begin
              pp_match = 1'b0;
              pp_phase = PP_HSIZE;
            end
          end else begin
            pp_phase = PP_CSIZE;
          end
        end
      end
      PP_HSIZE: begin
        pp_gather = {pp_gather[23:0], w.data_byte};
        if (pp_count < 3'd3) begin
          pp_count = pp_count + 3'd1;
        end else begin
          pp_count = '0;
          if (pp_gather != mcp_pkg::HEADER_SIZE) begin
            raise_error(mcp_pkg::ERR_INVALID_FORMAT);
          end else begin
            pp_gather = '0;
            pp_phase  = PP_HWORDS;
          end
        end
      end
      PP_HWORDS: begin
        // format and track count fill the word, the timebase then shifts through its low half
        if (pp_count < 3'd4) begin
          pp_gather = {pp_gather[23:0], w.data_byte};
          if (pp_count == 3'd3) pp_declared = pp_gather[15:0];
        end else begin
          pp_gather = {pp_gather[31:16], pp_gather[7:0], w.data_byte};
        end
        if (pp_count < 3'd5) begin
          pp_count = pp_count + 3'd1;
        end else begin
          pp_count         = '0;
          pp_phase         = (pp_declared == 16'd0) ? PP_DONE : PP_CMAGIC;
          r.result_kind    = mcp_pkg::KIND_HEADER;
          r.format_type    = pp_gather[31:16];
          r.track_total    = pp_declared;
          r.ticks_per_beat = pp_gather[15:0];
          r.finished       = (pp_declared == 16'd0);
          expected_reports.push_back(r);
        end
      end
      PP_CSIZE: begin
        pp_gather = {pp_gather[23:0], w.data_byte};
        if (pp_count < 3'd3) begin
          pp_count = pp_count + 3'd1;
        end else begin
          pp_count  = '0;
          len       = pp_gather;
          pp_gather = '0;
          if (pp_match) begin
            r.result_kind  = mcp_pkg::KIND_TRACK;
            r.track_number = pp_found;
            pp_found       = pp_found + 16'd1;
            r.body_offset  = pp_position;
            r.body_length  = len;
            r.finished     = (len == 32'd0) && (pp_found == pp_declared);
            expected_reports.push_back(r);
          end
          pp_match = 1'b0;
          if (len == 32'd0) begin
            pp_phase = (pp_found == pp_declared) ? PP_DONE : PP_CMAGIC;
          end else begin
            pp_skip  = len;
            pp_phase = PP_SKIP;
          end
        end
      end
      PP_SKIP: begin
        pp_skip = pp_skip - 32'd1;
        if (pp_skip == 32'd0) begin
          if (pp_found == pp_declared) begin
            pp_phase      = PP_DONE;
            r.result_kind = mcp_pkg::KIND_COMPLETE;
            r.finished    = 1'b1;
            expected_reports.push_back(r);
          end else begin
            pp_phase = PP_CMAGIC;
          end
        end
      end
      default: ;
    endcase
  endtask

  // offers one word, with random idle cycles in front, and predicts on accept
  task automatic send_word(input mcp_pkg::in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_word  <= w;
    do @(posedge clk); while (!src_ready);
    predict_report(w);
  endtask

  task automatic hold_src();
    src_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender pause until every predicted report has come out
  task automatic wait_drained();
    hold_src();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic append_be(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
  endtask

  // sends file_bytes; a stream end replaces the byte at cut (none when cut < 0)
  task automatic send_bytes(input int cut);
    mcp_pkg::in_word_t w;
    for (int k = 0; k <= file_bytes.size(); k++) begin
      w.start_of_file = (k == 0);
      w.stream_ended  = (k == cut);
      w.data_byte     = (k == cut || k == file_bytes.size()) ? 8'($urandom) : file_bytes[k];
      if (k == cut || k < file_bytes.size()) send_word(w);
      if (k == cut) break;
    end
  endtask

  task automatic build_random_file();
    int          ntrk;
    int          len;
    logic [31:0] magic;
    file_bytes.delete();
    append_be(HDR_MAGIC, 4);
    append_be(mcp_pkg::HEADER_SIZE, 4);
    append_be(($urandom_range(9) < 7) ? $urandom_range(2) : $urandom, 2);
    ntrk = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2);
    append_be(ntrk, 2);
    append_be($urandom, 2);
    for (int t = 0; t < ntrk; t++) begin
      // foreign chunk, either random or one bit away from a track magic
      if ($urandom_range(5) == 0) begin
        magic = $urandom_range(1) ? $urandom : (TRK_MAGIC ^ (32'h1 << $urandom_range(31)));
        len   = $urandom_range(3);
        append_be(magic, 4);
        append_be(len, 4);
        repeat (len) file_bytes.push_back(8'($urandom));
      end
      append_be(TRK_MAGIC, 4);
      if ($urandom_range(24) == 0) begin
        // huge size: body never ends, next start recovers
        append_be($urandom | 32'h8000_0000, 4);
        repeat (2) file_bytes.push_back(8'($urandom));
        break;
      end
      len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3);
      append_be(len, 4);
      repeat (len) file_bytes.push_back(8'($urandom));
    end
  endtask

  // clean, cut short, with one corrupted byte, or clean with trailing noise
  task automatic send_random_file(output int n);
    int mode;
    int cut;
    int idx;
    build_random_file();
    mode = $urandom_range(9);
    cut  = -1;
    if (mode >= 6 && mode <= 8) begin
      cut = $urandom_range(file_bytes.size() - 1);
    end else if (mode == 9) begin
      idx             = $urandom_range(file_bytes.size() - 1);
      file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
    end else if ($urandom_range(2) == 0) begin
      // trailing noise and a late stream end, dropped if the file has completed
      repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
      cut = file_bytes.size();
    end
    n = (cut >= 0 && cut < file_bytes.size()) ? cut + 1 : file_bytes.size();
    send_bytes(cut);
  endtask

  task automatic test_idle_input();
    mcp_pkg::in_word_t w;
    w = '{start_of_file: 1'b0, data_byte: 8'hFF, stream_ended: 1'b0};
    send_word(w);
    w = '{start_of_file: 1'b0, data_byte: 8'h00, stream_ended: 1'b1};
    send_word(w);
  endtask

  task automatic test_empty_stream();
    mcp_pkg::in_word_t w;
    w = '{start_of_file: 1'b1, data_byte: 8'hA5, stream_ended: 1'b1};
    send_word(w);
  endtask

  task automatic test_bad_magic();
    file_bytes.delete();
    append_be(32'h4D546865, 4);
    file_bytes.push_back(8'h4D);
    send_bytes(-1);
  endtask

  task automatic test_zero_tracks();
    file_bytes.delete();
    append_be(HDR_MAGIC, 4);
    append_be(mcp_pkg::HEADER_SIZE, 4);
    append_be(32'hFFFF, 2);
    append_be(32'h0, 2);
    append_be(32'hFFFF, 2);
    file_bytes.push_back(8'hFF);
    send_bytes(-1);
  endtask

  task automatic test_random_files(input int target);
    int sent;
    int n;
    sent = 0;
    while (sent < target) begin
      send_random_file(n);
      sent += n;
    end
    wait_drained();
  endtask

  // many empty tracks while the receiver holds off: output stage fills up
  task automatic test_backpressure();
    file_bytes.delete();
    append_be(HDR_MAGIC, 4);
    append_be(mcp_pkg::HEADER_SIZE, 4);
    append_be(32'd1, 2);
    append_be(32'd12, 2);
    append_be(32'd480, 2);
    repeat (12) begin
      append_be(TRK_MAGIC, 4);
      append_be(32'd0, 4);
    end
    hold_off_len = 300;
    hold_off_id  = hold_off_id + 1;
    send_bytes(-1);
    wait_drained();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_off_id != hold_off_seen) begin
      hold_off_seen <= hold_off_id;
      hold_left     <= hold_off_len;
      res_ready     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= res_idle_pct);
    end
  end

  // monitor: each accepted res word against the oldest prediction
  always @(posedge clk) begin
    mcp_pkg::out_word_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected res word, kind %0d", res_word.result_kind);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("result_kind", want.result_kind, res_word.result_kind);
        check_field("format_type", want.format_type, res_word.format_type);
        check_field("track_total", want.track_total, res_word.track_total);
        check_field("ticks_per_beat", want.ticks_per_beat, res_word.ticks_per_beat);
        check_field("track_number", want.track_number, res_word.track_number);
        check_field("body_offset", want.body_offset, res_word.body_offset);
        check_field("body_length", want.body_length, res_word.body_length);
        check_field("finished", want.finished, res_word.finished);
        check_field("error_code", want.error_code, res_word.error_code);
      end
    end
  end

  initial begin
    reset_parser();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_input();
    test_empty_stream();
    test_bad_magic();
    test_zero_tracks();
    wait_drained();

    src_idle_pct = 18;
    res_idle_pct = 73;
    test_random_files(250);

    src_idle_pct = 73;
    res_idle_pct = 18;
    test_random_files(250);

    src_idle_pct = 0;
    res_idle_pct = 0;
    test_random_files(220);
    test_backpressure();

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
